FILE: design/sps_pkg.sv
package sps_pkg;

  typedef struct packed {
    logic [19:0] range_low;
    logic [19:0] range_high;
  } sps_in_t;

  typedef struct packed {
    logic [19:0] prime_value;
    logic        has_prime;
    logic        range_error;
    logic        last;
  } sps_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ROOT,
    ST_BCLR,
    ST_BOUT,
    ST_BIN,
    ST_SSTART,
    ST_SMOD,
    ST_SMARK,
    ST_EMIT,
    ST_HOLD
  } sps_state_t;

endpackage

FILE: design/segmented_prime_sieve_unit.sv
// Segmented prime sieve. One transfer on the input channel carries a range
// [range_low, range_high]; the unit answers with one result per prime of the
// range in ascending order, the final one marked with last. An empty range,
// a range wider than SEG_SIZE or a range without primes gives a single result
// with has_prime low. For a range that is sieved, the integer root is found
// by stepping a counter, the base bitmap is set one entry per cycle and sieved
// one entry per cycle through one memory port, every candidate base value up
// to the root is visited, each base prime finds its first multiple in the
// range with a bit-serial remainder step over range_low, the segment is
// marked one multiple per cycle, and emission scans one segment bit per
// cycle, waiting while the result register is stalled. The input stall is
// high from the accepted transfer until the last result is taken.
module segmented_prime_sieve_unit import sps_pkg::*; #(
  parameter int SEG_SIZE   = 64,
  parameter int ROOT_LIMIT = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sps_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sps_out_t out_data
);

  localparam int RW = $clog2(ROOT_LIMIT);
  localparam int SW = $clog2(SEG_SIZE);

  sps_state_t state_r, state_nxt;
  logic [19:0] lo_r, hi_r;
  logic [RW-1:0] root_r;
  logic [RW:0] i_r;
  logic [20:0] j_r;
  logic [21:0] sq_r;
  logic [SEG_SIZE-1:0] seg_r;
  logic base_mem [ROOT_LIMIT];
  logic base_rd_r;
  logic found_r;
  logic [19:0] pend_r;
  logic [RW:0] rem_r;
  logic [4:0] cnt_r;
  sps_out_t res_r;
  logic res_v_r;

  logic [20:0] off;
  logic [20:0] ip;
  logic [20:0] root_w;
  logic [RW+1:0] rem_sh;
  logic [RW+1:0] rem_diff;
  logic [RW:0] rem_step;
  logic [RW-1:0] rd_addr;
  logic out_free;
  logic res_set;

  assign off = j_r - {1'b0, lo_r};
  assign ip = {{(20-RW){1'b0}}, i_r};
  assign root_w = {{(21-RW){1'b0}}, root_r};
  assign rem_sh = {rem_r, lo_r[cnt_r]};
  assign rem_diff = rem_sh - {1'b0, i_r};
  assign rem_step = (rem_sh >= {1'b0, i_r}) ? rem_diff[RW:0] : rem_sh[RW:0];

  assign out_free = !res_v_r || !out_stall;
  assign res_set = out_free && ((state_r == ST_EMIT && j_r <= {1'b0, hi_r} &&
                   seg_r[off[SW-1:0]] && found_r) || state_r == ST_HOLD);

  assign in_stall = (state_r != ST_IDLE) || res_v_r;
  assign out_valid = res_v_r;
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid && !in_stall) state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (hi_r < 20'd2 || lo_r > hi_r) state_nxt = ST_HOLD;
        else if ({1'b0, hi_r} - {1'b0, lo_r} + 21'd1 > 21'(SEG_SIZE)) state_nxt = ST_HOLD;
        else state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        if (32'(root_r) + 1 >= ROOT_LIMIT || sq_r > {2'b0, hi_r}) state_nxt = ST_BCLR;
      end
      ST_BCLR: if (i_r == (RW+1)'(ROOT_LIMIT - 1)) state_nxt = ST_BOUT;
      ST_BOUT: begin
        if (i_r > {1'b0, root_r}) state_nxt = ST_SSTART;
        else state_nxt = ST_BIN;
      end
      ST_BIN: begin
        if (j_r > root_w) state_nxt = ST_BOUT;
      end
      ST_SSTART: begin
        if (i_r > {1'b0, root_r}) state_nxt = ST_EMIT;
        else if (base_rd_r && i_r != '0) state_nxt = ST_SMOD;
        else state_nxt = ST_SMARK;
      end
      ST_SMOD: if (cnt_r == 5'd0) state_nxt = ST_SMARK;
      ST_SMARK: begin
        if (j_r > {1'b0, hi_r}) state_nxt = ST_SSTART;
      end
      ST_EMIT: begin
        if (out_free && j_r > {1'b0, hi_r}) state_nxt = ST_HOLD;
      end
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (state_r == ST_BOUT && state_nxt == ST_SSTART) rd_addr = RW'(2);
    else if (state_r == ST_BOUT || state_r == ST_SMOD || state_r == ST_SMARK)
      rd_addr = i_r[RW-1:0] + RW'(1);
    else rd_addr = i_r[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_BCLR) base_mem[i_r[RW-1:0]] <= 1'b1;
    else if (state_r == ST_BIN && base_rd_r && j_r <= root_w)
      base_mem[j_r[RW-1:0]] <= 1'b0;
    base_rd_r <= base_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_v_r <= res_set || (res_v_r && out_stall);
      unique case (state_r)
        ST_IDLE: if (in_valid && !in_stall) begin
          lo_r <= in_data.range_low;
          hi_r <= in_data.range_high;
        end
        ST_CHECK: begin
          root_r <= '0;
          sq_r <= 22'd1;
          found_r <= 1'b0;
          seg_r <= '1;
          i_r <= '0;
          res_r <= '{prime_value: '0, has_prime: 1'b0,
                     range_error: !(hi_r < 20'd2 || lo_r > hi_r), last: 1'b1};
        end
        ST_ROOT: if (state_nxt == ST_ROOT) begin
          sq_r <= sq_r + {{(21-RW){1'b0}}, root_r, 1'b0} + 22'd3;
          root_r <= root_r + RW'(1);
        end
        ST_BCLR: begin
          res_r.range_error <= 1'b0;
          if (state_nxt == ST_BOUT) i_r <= (RW+1)'(1);
          else i_r <= i_r + (RW+1)'(1);
        end
        ST_BOUT: begin
          if (state_nxt == ST_SSTART) i_r <= (RW+1)'(1);
          else begin
            i_r <= i_r + (RW+1)'(1);
            j_r <= 21'(ip + 21'd1) * 21'(ip + 21'd1);
          end
        end
        ST_BIN: begin
          if (j_r <= root_w) j_r <= j_r + ip;
        end
        ST_SSTART: begin
          if (state_nxt == ST_EMIT) begin
            j_r <= (lo_r > 20'd1) ? {1'b0, lo_r} : 21'd2;
          end else begin
            i_r <= i_r + (RW+1)'(1);
            rem_r <= '0;
            cnt_r <= 5'd19;
            if (!base_rd_r || i_r == '0) j_r <= 21'h1FFFFF;
            else j_r <= 21'(ip + 21'd1) * 21'(ip + 21'd1);
          end
        end
        ST_SMOD: begin
          rem_r <= rem_step;
          cnt_r <= cnt_r - 5'd1;
        end
        ST_SMARK: begin
          if (j_r < {1'b0, lo_r}) begin
            j_r <= (rem_r == '0) ? {1'b0, lo_r} :
                   {1'b0, lo_r} + ip - {{(20-RW){1'b0}}, rem_r};
          end else if (j_r <= {1'b0, hi_r}) begin
            seg_r[off[SW-1:0]] <= 1'b0;
            j_r <= j_r + ip;
          end
        end
        ST_EMIT: if (out_free && j_r <= {1'b0, hi_r}) begin
          if (seg_r[off[SW-1:0]]) begin
            if (found_r) begin
              res_r <= '{prime_value: pend_r, has_prime: 1'b1, range_error: 1'b0,
                         last: 1'b0};
            end
            found_r <= 1'b1;
            pend_r <= j_r[19:0];
          end
          j_r <= j_r + 21'd1;
        end
        ST_HOLD: if (out_free) begin
          if (found_r) begin
            res_r <= '{prime_value: pend_r, has_prime: 1'b1, range_error: 1'b0,
                       last: 1'b1};
          end else begin
            res_r.last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input accepted while busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last) |=> (state_r == ST_IDLE || state_r == ST_CHECK))
    else $error("last result left the unit busy");
  a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.range_error) |-> (!out_data.has_prime && out_data.last))
    else $error("error result carries a prime");

endmodule

FILE: verif/tb_segmented_prime_sieve_unit.sv
`timescale 1ns / 100ps

module tb_segmented_prime_sieve_unit;
  import sps_pkg::*;

  localparam int SEG = 64;
  localparam int RLIM = 1024;
  localparam longint CYCLE_LIMIT = 10000000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  sps_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  sps_out_t out_data;

  sps_out_t primes_due[$];
  int       errors;
  longint   cycles;
  int       send_idle_pct;
  int       recv_idle_pct;

  segmented_prime_sieve_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic sps_out_t make_res(logic [19:0] v, logic h, logic e, logic f);
    sps_out_t r;
    r.prime_value = v;
    r.has_prime = h;
    r.range_error = e;
    r.last = f;
    return r;
  endfunction

  task automatic predict_primes(logic [19:0] lo, logic [19:0] hi);
    bit          base [RLIM];
    bit          seg [SEG];
    int unsigned root;
    int unsigned st;
    int unsigned m;
    int unsigned first;
    int          count;
    count = 0;
    if (hi < 2 || lo > hi) begin
      primes_due = {primes_due, make_res('0, 1'b0, 1'b0, 1'b1)};
      return;
    end
    if (int'(hi) - int'(lo) + 1 > SEG) begin
      primes_due = {primes_due, make_res('0, 1'b0, 1'b1, 1'b1)};
      return;
    end
    foreach (base[k]) base[k] = 1'b1;
    foreach (seg[k]) seg[k] = 1'b1;
    root = 0;
    while (root + 1 < RLIM && (root + 1) * (root + 1) <= hi) root++;
    for (int unsigned i = 2; i * i <= root; i++) begin
      if (base[i]) begin
        for (int unsigned j = i * i; j <= root; j += i) base[j] = 1'b0;
      end
    end
    for (int unsigned i = 2; i <= root; i++) begin
      if (base[i]) begin
        st = i * i;
        m = ((lo + i - 1) / i) * i;
        if (m > st) st = m;
        for (int unsigned j = st; j <= hi; j += i) seg[j - lo] = 1'b0;
      end
    end
    first = (lo > 1) ? lo : 2;
    for (int unsigned i = first; i <= hi; i++) begin
      if (seg[i - lo]) begin
        primes_due = {primes_due, make_res(20'(i), 1'b1, 1'b0, 1'b0)};
        count++;
      end
    end
    if (count == 0) begin
      primes_due = {primes_due, make_res('0, 1'b0, 1'b0, 1'b1)};
    end else begin
      primes_due[primes_due.size() - 1].last = 1'b1;
    end
  endtask

  task automatic send_range(logic [19:0] lo, logic [19:0] hi);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data.range_low <= lo;
    in_data.range_high <= hi;
    predict_primes(lo, hi);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (primes_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_near(logic [19:0] base, int span);
    logic [19:0] hi;
    hi = (int'(base) + span > 1048575) ? 20'hFFFFF : 20'(int'(base) + span);
    send_range(base, hi);
  endtask

  task automatic test_directed();
    send_range(20'd0, 20'd0);
    send_range(20'd0, 20'd1);
    send_range(20'd0, 20'd2);
    send_range(20'd5, 20'd3);
    send_range(20'd0, 20'd63);
    send_range(20'd0, 20'd64);
    send_range(20'd2, 20'd65);
    send_range(20'd24, 20'd28);
    send_range(20'd1, 20'd1);
    send_range(20'd1048512, 20'hFFFFF);
    send_range(20'hFFFFF, 20'hFFFFF);
    send_range(20'hFFFFF, 20'd0);
    send_range(20'd0, 20'hFFFFF);
    send_range(20'd1046520, 20'd1046583);
    send_range(20'd1044000, 20'd1044063);
    send_range(20'd961, 20'd1000);
    send_range(20'd2, 20'd2);
    send_range(20'd524287, 20'd524300);
    send_range(20'h55555, 20'h55594);
    send_range(20'hAAAAA, 20'hAAAE9);
    drain_results();
  endtask

  task automatic test_random(int n);
    int sel;
    logic [19:0] a;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      a = 20'($urandom);
      if (sel < 60) send_near(a, $urandom_range(63));
      else if (sel < 75) send_near(20'($urandom_range(200)), $urandom_range(63));
      else if (sel < 85) send_near(a, $urandom_range(64, 5000));
      else send_range(a, 20'($urandom));
    end
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    errors = 0;
    send_idle_pct = 34;
    recv_idle_pct = 68;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(40);
    send_idle_pct = 68;
    recv_idle_pct = 34;
    test_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(40);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    sps_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (primes_due.size() == 0) begin
        $display("%0t unexpected transfer expected none actual %p", $time, out_data);
        errors++;
      end else begin
        want = primes_due.pop_front();
        if (out_data.prime_value !== want.prime_value)
          $display("%0t prime_value expected %0d actual %0d", $time,
                   want.prime_value, out_data.prime_value);
        if (out_data.has_prime !== want.has_prime)
          $display("%0t has_prime expected %0b actual %0b", $time,
                   want.has_prime, out_data.has_prime);
        if (out_data.range_error !== want.range_error)
          $display("%0t range_error expected %0b actual %0b", $time,
                   want.range_error, out_data.range_error);
        if (out_data.last !== want.last)
          $display("%0t last expected %0b actual %0b", $time,
                   want.last, out_data.last);
        if (out_data !== want) errors++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
